@@ rtl/dcd_pkg.sv @@
`default_nettype none

package dcd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd4;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd328;
  localparam logic [LEN_W-1:0]    WINDOW_RESET    = 10'd250;
  localparam logic [LEN_W-1:0]    GAP_RESET       = 10'd50;
  localparam logic [LEN_W-1:0]    HOLDOFF_RESET   = 10'd50;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_GAP    = 2'd1,
    PH_SECOND = 2'd2,
    PH_HOLD   = 2'd3
  } phase_t;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic       double_clap;
    logic       activated;
    logic [1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold_fraction;
    logic [LEN_W-1:0]    window_length;
    logic [LEN_W-1:0]    gap_length;
    logic [LEN_W-1:0]    holdoff_length;
    logic                detector_enable;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] old_sample;
    logic                old_valid;
  } ring_rd_t;

endpackage

`default_nettype wire

@@ rtl/dcd_ring.sv @@
`default_nettype none

module dcd_ring #(
  parameter int DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [dcd_pkg::SAMPLE_W-1:0]  wr_sample,
  output dcd_pkg::ring_rd_t                  rd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [dcd_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [dcd_pkg::SAMPLE_W-1:0] rd_data;
  logic                         rd_valid;
  logic [AW-1:0]                wp;
  logic [AW-1:0]                nx;
  logic                         primed;

  assign nx = (wp == LAST) ? '0 : wp + AW'(1);

  // write the new sample and fetch the oldest one in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_sample;
      rd_data <= mem[nx];
    end
  end

  // the oldest slot holds real data once the pointer has reached the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      primed   <= 1'b0;
      rd_valid <= 1'b0;
    end else if (wr_en) begin
      wp       <= nx;
      rd_valid <= primed || (wp == LAST);
      if (wp == LAST) begin
        primed <= 1'b1;
      end
    end
  end

  always_comb begin
    rd.old_sample = rd_data;
    rd.old_valid  = rd_valid;
  end

endmodule

`default_nettype wire

@@ rtl/dcd_seq.sv @@
`default_nettype none

module dcd_seq (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire dcd_pkg::in_item_t item,
  input  wire dcd_pkg::ring_rd_t rd,
  input  wire dcd_pkg::cfg_t     cfg,
  output dcd_pkg::out_item_t res
);

  dcd_pkg::phase_t            phase;
  dcd_pkg::phase_t            phase_next;
  logic [dcd_pkg::LEN_W-1:0]  count;
  logic [dcd_pkg::LEN_W-1:0]  count_next;
  logic                       pending;
  logic                       pending_next;

  logic [dcd_pkg::SAMPLE_W-1:0] old_val;
  logic [dcd_pkg::SAMPLE_W:0]   scale;
  logic [32:0]                  lhs;
  logic [32:0]                  rhs;
  logic                         clap;
  logic [dcd_pkg::LEN_W-1:0]    cnt_inc;
  logic [dcd_pkg::LEN_W-1:0]    len_cur;
  logic [dcd_pkg::LEN_W-1:0]    len_eff;
  logic                         done;

  // skip a zero-length gap or holdoff straight into the phase after it
  function automatic dcd_pkg::phase_t entry_phase(dcd_pkg::phase_t p,
                                                   dcd_pkg::cfg_t c);
    dcd_pkg::phase_t r;
    r = p;
    if (p == dcd_pkg::PH_GAP && c.gap_length == '0) begin
      r = dcd_pkg::PH_SECOND;
    end
    if (p == dcd_pkg::PH_HOLD && c.holdoff_length == '0) begin
      r = dcd_pkg::PH_FIRST;
    end
    return r;
  endfunction

  assign old_val = rd.old_valid ? rd.old_sample : '0;
  assign scale   = 17'h10000 - {1'b0, cfg.threshold_fraction};
  assign lhs     = 33'(item.sample) * 33'(scale);
  assign rhs     = {1'b0, old_val, 16'h0000};
  assign clap    = lhs > rhs;

  assign cnt_inc = count + 10'd1;

  always_comb begin
    case (phase)
      dcd_pkg::PH_FIRST:  len_cur = cfg.window_length;
      dcd_pkg::PH_GAP:    len_cur = cfg.gap_length;
      dcd_pkg::PH_SECOND: len_cur = cfg.window_length;
      dcd_pkg::PH_HOLD:   len_cur = cfg.holdoff_length;
      default:            len_cur = cfg.window_length;
    endcase
  end

  assign len_eff = (len_cur == '0) ? 10'd1 : len_cur;
  assign done    = cnt_inc >= len_eff;

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    pending_next    = pending;
    res.double_clap = 1'b0;
    res.activated   = 1'b0;
    res.phase       = phase;
    if (item.op == dcd_pkg::OP_READ) begin
      res.activated = pending;
      pending_next  = 1'b0;
    end else begin
      case (phase)
        dcd_pkg::PH_FIRST: begin
          if (clap) begin
            phase_next = entry_phase(dcd_pkg::PH_GAP, cfg);
            count_next = '0;
          end else if (done) begin
            phase_next = dcd_pkg::PH_FIRST;
            count_next = '0;
          end else begin
            count_next = cnt_inc;
          end
        end
        dcd_pkg::PH_GAP: begin
          if (done) begin
            phase_next = dcd_pkg::PH_SECOND;
            count_next = '0;
          end else begin
            count_next = cnt_inc;
          end
        end
        dcd_pkg::PH_SECOND: begin
          if (clap) begin
            res.double_clap = 1'b1;
            if (cfg.detector_enable) begin
              pending_next = 1'b1;
            end
            phase_next = entry_phase(dcd_pkg::PH_HOLD, cfg);
            count_next = '0;
          end else if (done) begin
            phase_next = dcd_pkg::PH_FIRST;
            count_next = '0;
          end else begin
            count_next = cnt_inc;
          end
        end
        default: begin
          if (done) begin
            phase_next = dcd_pkg::PH_FIRST;
            count_next = '0;
          end else begin
            count_next = cnt_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= dcd_pkg::PH_FIRST;
      count   <= '0;
      pending <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      count   <= count_next;
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/double_clap_detector.sv @@
// Double clap detector.
// Input channel in_valid/in_stall/in_data carries one request per item: a
// sample tick (op 0) or a read-and-clear of the activation flag (op 1).
// Output channel out_valid/out_stall/out_data returns exactly one result per
// request, in order. The user must write registers through cfg_write/
// cfg_index/cfg_data only while the block is idle; the block itself does not
// enforce this. Unknown indexes are ignored. A request accepted at the input
// is registered in the compare stage, beside the ring's read of the oldest
// sample; compare and sequencer update then fill the output register.
// Throughput: one request per cycle while the receiver does not stall; the
// sample ring writes the new sample and reads the oldest on each sample request.
// A stalled result holds in the output register while one more request waits
// in the compare stage; in_stall rises only when both are full.
// Reset clears the pipeline, the sequencer to first window, the pending flag
// and the registers to their defaults. The ring is not swept: a fill flag
// treats slots not yet written as zero, so requests are taken straight away.
`default_nettype none

module double_clap_detector #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire dcd_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output dcd_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_write,
  input  wire logic [dcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dcd_pkg::SAMPLE_W-1:0]   cfg_data
);

  dcd_pkg::cfg_t      cfg;
  dcd_pkg::in_item_t  s1_item;
  logic               s1_valid;
  logic               s1_move;
  logic               in_accept;
  dcd_pkg::ring_rd_t  rd;
  dcd_pkg::out_item_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_fraction <= dcd_pkg::THRESHOLD_RESET;
      cfg.window_length      <= dcd_pkg::WINDOW_RESET;
      cfg.gap_length         <= dcd_pkg::GAP_RESET;
      cfg.holdoff_length     <= dcd_pkg::HOLDOFF_RESET;
      cfg.detector_enable    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        dcd_pkg::CFG_THRESHOLD: cfg.threshold_fraction <= cfg_data;
        dcd_pkg::CFG_WINDOW:    cfg.window_length  <= cfg_data[dcd_pkg::LEN_W-1:0];
        dcd_pkg::CFG_GAP:       cfg.gap_length     <= cfg_data[dcd_pkg::LEN_W-1:0];
        dcd_pkg::CFG_HOLDOFF:   cfg.holdoff_length <= cfg_data[dcd_pkg::LEN_W-1:0];
        dcd_pkg::CFG_ENABLE:    cfg.detector_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_move;
  assign in_accept = in_valid && !in_stall;

  dcd_ring #(
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_accept && (in_data.op == dcd_pkg::OP_SAMPLE)),
    .wr_sample (in_data.sample),
    .rd        (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_data;
    end
  end

  dcd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (s1_move),
    .item (s1_item),
    .rd   (rd),
    .cfg  (cfg),
    .res  (res)
  );

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= res;
    end
  end

  a_double_in_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.double_clap |-> out_data.phase == dcd_pkg::PH_SECOND)
    else $error("double clap reported outside the second window");

  a_clap_or_read: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.double_clap && out_data.activated))
    else $error("result carries both a double clap and a read flag");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid && $stable(s1_item))
    else $error("compare stage lost its request under a stall");

endmodule

`default_nettype wire

@@ sim/double_clap_checker.sv @@
`default_nettype none

module double_clap_checker
  import dcd_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire in_item_t             in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire out_item_t            out_data,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SAMPLE_W-1:0]  cfg_data,
  output int                        fail_count,
  output int                        outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 30;

  logic [SAMPLE_W-1:0] sample_hist [RING_DEPTH];
  int unsigned         hist_wr;
  phase_t              seq_phase;
  logic [LEN_W-1:0]    phase_cnt;
  logic                activation_pending;
  cfg_t                regs;
  out_item_t           expected_results [$];
  int                  mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t ns: double_clap mismatch: %s", $realtime, what);
    end
  endtask

  function automatic logic phase_expired(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] lim;
    lim = (len == '0) ? LEN_W'(1) : len;
    phase_cnt = phase_cnt + 1'b1;
    return phase_cnt >= lim;
  endfunction

  // Skip a gap or holdoff whose length is zero
  function automatic void enter_phase(input phase_t target);
    phase_t nxt;
    nxt = target;
    phase_cnt = '0;
    if (nxt == PH_GAP && regs.gap_length == '0) nxt = PH_SECOND;
    if (nxt == PH_HOLD && regs.holdoff_length == '0) nxt = PH_FIRST;
    seq_phase = nxt;
  endfunction

  function automatic out_item_t predict_clap_result(input in_item_t req);
    out_item_t   res;
    int unsigned nxt;
    logic [32:0] scaled_new;
    logic [32:0] scaled_old;
    logic        clap;
    res = '0;
    res.phase = seq_phase;
    if (req.op == OP_READ) begin
      res.activated = activation_pending;
      activation_pending = 1'b0;
    end else begin
      nxt = (hist_wr + 1) % RING_DEPTH;
      sample_hist[hist_wr] = req.sample;
      scaled_new = 33'(req.sample) * (33'd65536 - 33'(regs.threshold_fraction));
      scaled_old = {1'b0, sample_hist[nxt], 16'h0000};
      clap = scaled_new > scaled_old;
      hist_wr = nxt;
      case (seq_phase)
        PH_FIRST: begin
          if (clap) enter_phase(PH_GAP);
          else if (phase_expired(regs.window_length)) enter_phase(PH_FIRST);
        end
        PH_GAP: begin
          if (phase_expired(regs.gap_length)) enter_phase(PH_SECOND);
        end
        PH_SECOND: begin
          if (clap) begin
            res.double_clap = 1'b1;
            if (regs.detector_enable) activation_pending = 1'b1;
            enter_phase(PH_HOLD);
          end else if (phase_expired(regs.window_length)) begin
            enter_phase(PH_FIRST);
          end
        end
        default: begin
          if (phase_expired(regs.holdoff_length)) enter_phase(PH_FIRST);
        end
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) sample_hist[i] = '0;
      hist_wr            = 0;
      seq_phase          = PH_FIRST;
      phase_cnt          = '0;
      activation_pending = 1'b0;
      regs = '{THRESHOLD_RESET, WINDOW_RESET, GAP_RESET, HOLDOFF_RESET, 1'b0};
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_THRESHOLD: regs.threshold_fraction = cfg_data;
          CFG_WINDOW:    regs.window_length      = cfg_data[LEN_W-1:0];
          CFG_GAP:       regs.gap_length         = cfg_data[LEN_W-1:0];
          CFG_HOLDOFF:   regs.holdoff_length     = cfg_data[LEN_W-1:0];
          CFG_ENABLE:    regs.detector_enable    = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_results.pop_front();
          if (out_data.double_clap !== want.double_clap)
            report_mismatch($sformatf("double_clap %b, want %b",
                                      out_data.double_clap, want.double_clap));
          if (out_data.activated !== want.activated)
            report_mismatch($sformatf("activated %b, want %b",
                                      out_data.activated, want.activated));
          if (out_data.phase !== want.phase)
            report_mismatch($sformatf("phase %0d, want %0d",
                                      out_data.phase, want.phase));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_clap_result(in_data));
      end
    end
    outstanding <= expected_results.size();
    fail_count  <= mismatches;
  end

endmodule

`default_nettype wire

@@ sim/double_clap_detector_tb.sv @@
`default_nettype none

module double_clap_detector_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dcd_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam int SEGMENTS   = 8;
  localparam int SEG_ITEMS  = 75;
  localparam int LONG_HOLD  = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data  = '0;

  int fail_count;
  int outstanding;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  double_clap_detector #(
    .RING_DEPTH(RING_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  double_clap_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_item_t tick(input logic [SAMPLE_W-1:0] value);
    in_item_t r;
    r.op     = OP_SAMPLE;
    r.sample = value;
    return r;
  endfunction

  // Sample bits are don't-care on a read, so fill them with noise
  function automatic in_item_t read_req();
    in_item_t r;
    r.op     = OP_READ;
    r.sample = SAMPLE_W'($urandom);
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 20) return '1;
    return LEN_W'($urandom_range(12, 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return THRESHOLD_RESET;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic send_request(input in_item_t req);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Upper bits above each register's width carry noise; the block must drop them
  task automatic program_settings(input cfg_t s);
    wait_idle();
    write_reg(CFG_THRESHOLD, s.threshold_fraction);
    write_reg(CFG_WINDOW, {6'($urandom), s.window_length});
    write_reg(CFG_GAP, {6'($urandom), s.gap_length});
    write_reg(CFG_HOLDOFF, {6'($urandom), s.holdoff_length});
    write_reg(CFG_ENABLE, {15'($urandom), s.detector_enable});
    write_reg(CFG_UNUSED, SAMPLE_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  initial begin
    cfg_t                s;
    int                  r;
    logic [SAMPLE_W-1:0] level;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: first clap moves into the gap
    send_request(read_req());
    send_request(tick(16'd0));
    send_request(tick(16'hFFFF));
    send_request(tick(16'd1));
    send_request(read_req());

    // Full drop fraction, zero lengths: gap and holdoff skipped, window of one
    program_settings('{16'hFFFF, 10'd0, 10'd0, 10'd0, 1'b1});
    send_request(tick(16'hFFFF));
    send_request(tick(16'hFFFF));
    send_request(read_req());
    send_request(read_req());
    send_request(tick(16'hFFFF));
    send_request(tick(16'd0));
    send_request(tick(16'd0));

    // Disabled detector still reports the double clap
    program_settings('{16'd0, 10'd1023, 10'd2, 10'd1023, 1'b0});
    send_request(tick(16'd1));
    send_request(tick(16'd2));
    send_request(tick(16'd3));
    send_request(tick(16'd4));
    send_request(read_req());
    send_request(tick(16'd5));

    // Shorten the holdoff while in it: it ends on the next sample
    program_settings('{THRESHOLD_RESET, 10'd0, 10'd1023, 10'd1, 1'b1});
    send_request(tick(16'd0));
    send_request(tick(16'hFFFF));
    send_request(tick(16'd0));
    send_request(read_req());

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      s.threshold_fraction = pick_threshold();
      s.window_length      = pick_len();
      s.gap_length         = pick_len();
      s.holdoff_length     = pick_len();
      s.detector_enable    = 1'($urandom_range(1));
      program_settings(s);
      case (seg % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      level = SAMPLE_W'($urandom_range(4000));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // Hold the receiver off while requests keep coming, to fill the pipe
        if (seg % 4 == 0 && n == 30) hold_requests++;
        if (seg % 4 == 1 && n == 40) wait_idle();
        r = $urandom_range(99);
        if (r < 8) begin
          send_request(read_req());
        end else if (r < 55) begin
          send_request(tick(level));
        end else if (r < 72) begin
          send_request(tick(SAMPLE_W'($urandom_range(65535, 32768))));
        end else if (r < 90) begin
          send_request(tick(SAMPLE_W'($urandom)));
        end else begin
          level = SAMPLE_W'($urandom);
          send_request(tick(level));
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
